FILE: hw/rtl/lrr2_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the rotated 2bpp line rasterizer: parameter defaults,
// register indexes and reset values, rotation and mode codes, lane mask and field widths.
// No dependencies.
package lrr2_pkg;

    localparam int COORD_BITS_DEF    = 10;
    localparam int MAX_ROW_BYTES_DEF = 256;

    // Configuration register indexes
    localparam logic [1:0] REG_ROTATION   = 2'd0;
    localparam logic [1:0] REG_MEM_WIDTH  = 2'd1;
    localparam logic [1:0] REG_MEM_HEIGHT = 2'd2;
    localparam logic [1:0] REG_ROW_BYTES  = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;

    // Register reset values
    localparam logic [1:0]  RST_ROTATION   = 2'd0;
    localparam logic [10:0] RST_MEM_WIDTH  = 11'd400;
    localparam logic [10:0] RST_MEM_HEIGHT = 11'd300;
    localparam logic [8:0]  RST_ROW_BYTES  = 9'd100;

    // Rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Item modes
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // Lane mask of the leftmost pixel in a byte
    localparam logic [7:0] LANE0_MASK = 8'hC0;

    // Result field widths
    localparam int ADDR_W  = 18;
    localparam int BYTE_W  = 8;
    localparam int OUT_W   = 40;

endpackage

FILE: hw/rtl/line_rasterizer_rotated_2bpp_core.sv
`timescale 1ns / 1ps
// Output: a pixel write is registered and appears on the master side in the cycle after its
//   advance transaction is accepted; start transactions give no result.
// Throughput: one transaction per cycle while the master side keeps ready high;
//   the single output register is the only stall point (ready drops when full).
// Reset (synchronous, active low) idles the line engine, drops the pending
//   result and loads rotation 0, 400 x 300 pixels and 100 bytes per row.
// Depends on lrr2_pkg.
module line_rasterizer_rotated_2bpp_core #(
    parameter int COORD_BITS    = lrr2_pkg::COORD_BITS_DEF,
    parameter int MAX_ROW_BYTES = lrr2_pkg::MAX_ROW_BYTES_DEF,
    localparam int IN_W         = ((4 * COORD_BITS + 2 + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [lrr2_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lrr2_pkg::CFG_DATA_W-1:0] i_cfg_wdata,

    // slave side: command transactions
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata, low bit up: x_start, y_start, x_end, y_end, color, zero fill
    input  logic [IN_W-1:0]                 s_axis_tdata,
    // tuser: mode (0 start, 1 advance)
    input  logic                            s_axis_tuser,

    // master side: pixel write transactions
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata, low bit up: byte_addr[17:0], bit_mask[7:0], write_data[7:0], zero fill
    output logic [lrr2_pkg::OUT_W-1:0]      m_axis_tdata,
    // tuser: out_of_range
    output logic                            m_axis_tuser,
    // tlast: final pixel of the line
    output logic                            m_axis_tlast
);

    localparam int C  = COORD_BITS;
    localparam int EW = C + 3;                        // error term width
    localparam int SW = ((C > 11) ? C : 11) + 2;      // signed rotated coordinate width
    localparam logic [8:0] RB_CAP = 9'((MAX_ROW_BYTES > 511) ? 511 : MAX_ROW_BYTES);
    localparam logic signed [SW-1:0] ONE_S = {{(SW-1){1'b0}}, 1'b1};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  r_rotation;
    logic [10:0] r_mem_width;
    logic [10:0] r_mem_height;
    logic [8:0]  r_row_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation   <= lrr2_pkg::RST_ROTATION;
            r_mem_width  <= lrr2_pkg::RST_MEM_WIDTH;
            r_mem_height <= lrr2_pkg::RST_MEM_HEIGHT;
            r_row_bytes  <= lrr2_pkg::RST_ROW_BYTES;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lrr2_pkg::REG_ROTATION:   r_rotation   <= i_cfg_wdata[1:0];
                lrr2_pkg::REG_MEM_WIDTH:  r_mem_width  <= i_cfg_wdata[10:0];
                lrr2_pkg::REG_MEM_HEIGHT: r_mem_height <= i_cfg_wdata[10:0];
                lrr2_pkg::REG_ROW_BYTES:  r_row_bytes  <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking and handshake
    // ------------------------------------------------------------------
    logic [C-1:0] w_xs, w_ys, w_xe, w_ye;
    logic [1:0]   w_color;
    logic         w_in_fire;
    logic         w_start;
    logic         w_advance;

    assign w_xs    = s_axis_tdata[C-1:0];
    assign w_ys    = s_axis_tdata[2*C-1:C];
    assign w_xe    = s_axis_tdata[3*C-1:2*C];
    assign w_ye    = s_axis_tdata[4*C-1:3*C];
    assign w_color = s_axis_tdata[4*C+1:4*C];

    logic r_out_valid;

    // Take a new transaction whenever the output register is free or draining.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_start       = w_in_fire && (s_axis_tuser == lrr2_pkg::MODE_START);

    // ------------------------------------------------------------------
    // Line state
    // ------------------------------------------------------------------
    logic [C-1:0]         r_cur_x, r_cur_y, r_end_x, r_end_y;
    logic signed [EW-1:0] r_err;
    logic [C-1:0]         r_dx;
    logic signed [C:0]    r_ndy;
    logic                 r_step_x_neg, r_step_y_neg;
    logic [1:0]           r_line_color;
    logic                 r_busy;

    logic [C-1:0]         n_cur_x, n_cur_y;
    logic signed [EW-1:0] n_err;

    // Advance only emits while a line is active; idle advances are dropped.
    assign w_advance = w_in_fire && (s_axis_tuser == lrr2_pkg::MODE_ADVANCE) && r_busy;

    // Bresenham step decision: double the error once, before either axis moves.
    logic signed [EW:0] w_e2;
    logic               w_move_x, w_move_y;
    logic               w_is_last;

    assign w_e2     = {r_err, 1'b0};
    assign w_move_x = w_e2 >= $signed({{3{r_ndy[C]}}, r_ndy});
    assign w_move_y = w_e2 <= $signed({4'b0, r_dx});
    assign w_is_last = (w_move_x && (r_cur_x == r_end_x)) ||
                       (w_move_y && (r_cur_y == r_end_y));

    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_err   = r_err;
        if (w_move_x) begin
            n_err   = n_err + $signed({{2{r_ndy[C]}}, r_ndy});
            n_cur_x = r_step_x_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        end
        if (w_move_y) begin
            n_err   = n_err + $signed({3'b0, r_dx});
            n_cur_y = r_step_y_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        end
    end

    // Start item setup: absolute deltas and step directions.
    logic [C-1:0]      w_adx, w_ady;
    logic signed [C:0] w_start_ndy;

    assign w_adx       = (w_xe >= w_xs) ? w_xe - w_xs : w_xs - w_xe;
    assign w_ady       = (w_ye >= w_ys) ? w_ye - w_ys : w_ys - w_ye;
    assign w_start_ndy = -$signed({1'b0, w_ady});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_end_x      <= '0;
            r_end_y      <= '0;
            r_err        <= '0;
            r_dx         <= '0;
            r_ndy        <= '0;
            r_step_x_neg <= 1'b0;
            r_step_y_neg <= 1'b0;
            r_line_color <= '0;
            r_busy       <= 1'b0;
        end else if (w_start) begin
            // Drop any active line and load the new one.
            r_cur_x      <= w_xs;
            r_cur_y      <= w_ys;
            r_end_x      <= w_xe;
            r_end_y      <= w_ye;
            r_dx         <= w_adx;
            r_ndy        <= w_start_ndy;
            r_step_x_neg <= !(w_xs < w_xe);
            r_step_y_neg <= !(w_ys < w_ye);
            r_err        <= $signed({3'b0, w_adx}) + $signed({{2{w_start_ndy[C]}}, w_start_ndy});
            r_line_color <= w_color;
            r_busy       <= 1'b1;
        end else if (w_advance) begin
            if (w_is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                r_err   <= n_err;
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotation into memory coordinates and range check
    // ------------------------------------------------------------------
    logic signed [SW-1:0] w_x_s, w_y_s, w_w_s, w_h_s;
    logic signed [SW-1:0] w_mx, w_my, w_mx_byte;
    logic [8:0]           w_rb;
    logic                 w_oor;

    assign w_x_s = $signed({{(SW-C){1'b0}}, r_cur_x});
    assign w_y_s = $signed({{(SW-C){1'b0}}, r_cur_y});
    assign w_w_s = $signed({{(SW-11){1'b0}}, r_mem_width});
    assign w_h_s = $signed({{(SW-11){1'b0}}, r_mem_height});

    always_comb begin
        case (r_rotation)
            lrr2_pkg::ROT_0: begin
                w_mx = w_w_s - ONE_S - w_y_s;
                w_my = w_x_s;
            end
            lrr2_pkg::ROT_90: begin
                w_mx = w_w_s - ONE_S - w_x_s;
                w_my = w_h_s - ONE_S - w_y_s;
            end
            lrr2_pkg::ROT_180: begin
                w_mx = w_y_s;
                w_my = w_h_s - ONE_S - w_x_s;
            end
            default: begin
                w_mx = w_x_s;
                w_my = w_y_s;
            end
        endcase
    end

    // Limit the row pitch to the largest supported row.
    assign w_rb      = (r_row_bytes > RB_CAP) ? RB_CAP : r_row_bytes;
    assign w_mx_byte = w_mx >>> 2;
    assign w_oor     = w_mx[SW-1] || w_my[SW-1] || (w_mx >= w_w_s) || (w_my >= w_h_s) ||
                       (w_mx_byte >= $signed({{(SW-9){1'b0}}, w_rb}));

    // In range, both coordinates are below 2048 and fit 11 bits.
    logic [19:0] w_prod, w_sum;
    logic [1:0]  w_lane;

    assign w_prod = {9'b0, w_my[10:0]} * {11'b0, w_rb};
    assign w_sum  = w_prod + {11'b0, w_mx[10:2]};
    assign w_lane = w_mx[1:0];

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [lrr2_pkg::ADDR_W-1:0] r_addr;
    logic [lrr2_pkg::BYTE_W-1:0] r_mask;
    logic [lrr2_pkg::BYTE_W-1:0] r_data;
    logic                        r_oor;
    logic                        r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload carries no reset; it loads with each emitted pixel.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_oor  <= w_oor;
            r_last <= w_is_last;
            if (w_oor) begin
                // mask the write off instead of wrapping into another row
                r_addr <= '0;
                r_mask <= '0;
                r_data <= '0;
            end else begin
                r_addr <= w_sum[lrr2_pkg::ADDR_W-1:0];
                r_mask <= lrr2_pkg::LANE0_MASK >> {w_lane, 1'b0};
                r_data <= {r_line_color, 6'b0} >> {w_lane, 1'b0};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_data, r_mask, r_addr};
    assign m_axis_tuser  = r_oor;
    assign m_axis_tlast  = r_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_oor_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_oor) |-> (r_addr == '0 && r_mask == '0 && r_data == '0))
        else $error("out of range pixel carries a nonzero write");

    a_data_in_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_data & ~r_mask) == '0))
        else $error("write data outside the selected lane");

    a_one_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_oor) |-> (r_mask == 8'hC0 || r_mask == 8'h30 ||
                                     r_mask == 8'h0C || r_mask == 8'h03))
        else $error("in range pixel does not select exactly one lane");

    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_is_last) |=> (!r_busy && r_out_valid && r_last))
        else $error("final pixel did not end the line");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_busy && !r_out_valid || r_busy && $past(r_out_valid)))
        else $error("start transaction did not load a line");

endmodule
